/* hw/rtl/crt3_pkg.sv */
// Shared types, widths and the control program for the three-moduli CRT solver.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package crt3_pkg;

    localparam int MW    = 16;
    localparam int DW    = 2 * MW;
    localparam int BW    = 3 * MW;
    localparam int TW    = MW + 2;
    localparam int CW    = $clog2(DW + 1);
    localparam int IN_W  = 16;
    localparam int SOL_W = 48;
    localparam int PCW   = 5;
    localparam int ROM_N = 19;

    typedef enum logic [4:0] {
        OP_GINIT, OP_GTEST, OP_GDIV, OP_GCHK, OP_UNIT,
        OP_BIG1, OP_BIG2, OP_PART, OP_PMOD, OP_ETEST,
        OP_EDIV, OP_ETUP, OP_ICHK, OP_RMOD, OP_CMUL,
        OP_CMOD, OP_TMUL, OP_ACC, OP_DONE
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOCOP = 2'd1,
        ST_NOINV = 2'd2
    } t_status;

    typedef struct packed {
        t_op            op;
        logic [PCW-1:0] tgt;
    } t_uop;

    typedef struct packed {
        logic run;
        t_op  op;
    } t_ctl;

    typedef struct packed {
        logic    done;
        logic    cond;
        logic    fin;
        t_status status;
    } t_flg;

    localparam logic [PCW-1:0] A_GINIT = PCW'(0);
    localparam logic [PCW-1:0] A_GTEST = PCW'(1);
    localparam logic [PCW-1:0] A_GCHK  = PCW'(3);
    localparam logic [PCW-1:0] A_PART  = PCW'(7);
    localparam logic [PCW-1:0] A_ETEST = PCW'(9);
    localparam logic [PCW-1:0] A_ICHK  = PCW'(12);

    function automatic t_uop uc_rom(input logic [PCW-1:0] a);
        t_uop u;
        u.tgt = '0;
        case (a)
            PCW'(0):  u.op = OP_GINIT;
            PCW'(1):  begin u.op = OP_GTEST; u.tgt = A_GCHK;  end
            PCW'(2):  begin u.op = OP_GDIV;  u.tgt = A_GTEST; end
            PCW'(3):  begin u.op = OP_GCHK;  u.tgt = A_GINIT; end
            PCW'(4):  u.op = OP_UNIT;
            PCW'(5):  u.op = OP_BIG1;
            PCW'(6):  u.op = OP_BIG2;
            PCW'(7):  u.op = OP_PART;
            PCW'(8):  u.op = OP_PMOD;
            PCW'(9):  begin u.op = OP_ETEST; u.tgt = A_ICHK;  end
            PCW'(10): u.op = OP_EDIV;
            PCW'(11): begin u.op = OP_ETUP;  u.tgt = A_ETEST; end
            PCW'(12): u.op = OP_ICHK;
            PCW'(13): u.op = OP_RMOD;
            PCW'(14): u.op = OP_CMUL;
            PCW'(15): u.op = OP_CMOD;
            PCW'(16): u.op = OP_TMUL;
            PCW'(17): begin u.op = OP_ACC;   u.tgt = A_PART;  end
            default:  u.op = OP_DONE;
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/crt3_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on crt3_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module crt3_div
    import crt3_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [MW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quo,
    output logic [MW-1:0]      o_rem
);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [MW-1:0] r_rem, r_dvs;
    logic [MW:0]   w_trial, w_diff;
    logic          w_ge;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[MW-1:0] : w_trial[MW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

/* hw/rtl/crt3_seq.sv */
// Microprogram sequencer: step counter, control ROM and branch logic.
// Depends on crt3_pkg for the ROM and control types.
`timescale 1ns / 1ps
`default_nettype none
module crt3_seq
    import crt3_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_flg i_flg,
    input  wire logic i_out_free,
    output t_ctl      o_ctl,
    output logic      o_fire
);

    logic           r_run, n_run;
    logic [PCW-1:0] r_pc, n_pc;
    t_uop           w_uop;

    assign w_uop     = uc_rom(r_pc);
    assign o_ctl.run = r_run;
    assign o_ctl.op  = w_uop.op;
    assign o_fire    = r_run && i_flg.fin && i_out_free;

    always_comb begin
        n_run = r_run;
        n_pc  = r_pc;
        if (i_start) begin
            n_run = 1'b1;
            n_pc  = '0;
        end else if (r_run) begin
            if (i_flg.fin) begin
                if (i_out_free) begin
                    n_run = 1'b0;
                end
            end else if (i_flg.done) begin
                n_pc = i_flg.cond ? w_uop.tgt : r_pc + PCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pc  <= '0;
        end else begin
            r_run <= n_run;
            r_pc  <= n_pc;
        end
    end

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_run) else $error("request started while busy");
    a_start_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_run && r_pc == '0) else $error("program did not start");
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> r_pc < PCW'(ROM_N)) else $error("step counter out of program");
`endif

endmodule
`default_nettype wire

/* hw/rtl/crt3_dp.sv */
// Datapath: operand registers, shared multiplier and divider, driven per step.
// Depends on crt3_pkg and crt3_div.
`timescale 1ns / 1ps
`default_nettype none
module crt3_dp
    import crt3_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire logic [IN_W-1:0] i_mod0,
    input  wire logic [IN_W-1:0] i_mod1,
    input  wire logic [IN_W-1:0] i_mod2,
    input  wire logic [IN_W-1:0] i_res0,
    input  wire logic [IN_W-1:0] i_res1,
    input  wire logic [IN_W-1:0] i_res2,
    input  wire t_ctl            i_ctl,
    output t_flg                 o_flg,
    output logic [BW-1:0]        o_x
);

    logic                 r_wait;
    logic [1:0]           r_k;
    logic [MW-1:0]        r_m0, r_m1, r_m2, r_a0, r_a1, r_a2;
    logic [MW-1:0]        r_r0, r_r1, r_q, r_c;
    logic signed [TW-1:0] r_t0, r_t1;
    logic [DW-1:0]        r_part;
    logic [BW-1:0]        r_big, r_term, r_x;

    logic [MW-1:0]        m_k, a_k, g_a, g_b, o_a, o_b;
    logic                 div_start, div_done;
    logic [DW-1:0]        div_a, div_quo;
    logic [MW-1:0]        div_b, div_rem;
    logic [DW-1:0]        mul_a;
    logic [MW-1:0]        mul_b;
    logic [BW-1:0]        w_prod;
    logic signed [TW-1:0] w_qt, w_tpos;
    logic [BW:0]          w_sum, w_sub;
    logic                 w_last;

    crt3_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_comb begin
        case (r_k)
            2'd0: begin
                m_k = r_m0; a_k = r_a0; g_a = r_m0; g_b = r_m1; o_a = r_m1; o_b = r_m2;
            end
            2'd1: begin
                m_k = r_m1; a_k = r_a1; g_a = r_m1; g_b = r_m2; o_a = r_m0; o_b = r_m2;
            end
            default: begin
                m_k = r_m2; a_k = r_a2; g_a = r_m0; g_b = r_m2; o_a = r_m0; o_b = r_m1;
            end
        endcase
    end

    assign w_last = r_k == 2'd2;
    assign w_prod = BW'(mul_a) * BW'(mul_b);
    assign w_qt   = $signed({{(TW-MW){1'b0}}, r_q}) * r_t1;
    assign w_tpos = r_t0 + $signed({{(TW-MW){1'b0}}, m_k});
    assign w_sum  = {1'b0, r_x} + {1'b0, r_term};
    assign w_sub  = w_sum - {1'b0, r_big};

    always_comb begin
        div_start = 1'b0;
        div_a     = '0;
        div_b     = '0;
        mul_a     = '0;
        mul_b     = '0;
        o_flg     = '{done: 1'b1, cond: 1'b0, fin: 1'b0, status: ST_OK};
        case (i_ctl.op)
            OP_GINIT: o_flg.cond = 1'b0;
            OP_GTEST, OP_ETEST: o_flg.cond = r_r1 == '0;
            OP_GDIV, OP_EDIV: begin
                div_a      = DW'(r_r0);
                div_b      = r_r1;
                div_start  = i_ctl.run && !r_wait;
                o_flg.done = div_done;
                o_flg.cond = i_ctl.op == OP_GDIV;
            end
            OP_GCHK: begin
                o_flg.fin    = r_r0 != MW'(1);
                o_flg.status = ST_NOCOP;
                o_flg.cond   = !w_last;
            end
            OP_UNIT: begin
                o_flg.fin    = r_m0 < MW'(2) || r_m1 < MW'(2) || r_m2 < MW'(2);
                o_flg.status = ST_NOINV;
            end
            OP_BIG1: begin mul_a = DW'(r_m1); mul_b = r_m2; end
            OP_BIG2: begin mul_a = r_part;    mul_b = r_m0; end
            OP_PART: begin mul_a = DW'(o_a);  mul_b = o_b;  end
            OP_PMOD, OP_RMOD, OP_CMOD: begin
                div_a      = (i_ctl.op == OP_PMOD) ? r_part :
                             (i_ctl.op == OP_RMOD) ? DW'(a_k) : r_term[DW-1:0];
                div_b      = m_k;
                div_start  = i_ctl.run && !r_wait;
                o_flg.done = div_done;
            end
            OP_ETUP: o_flg.cond = 1'b1;
            OP_ICHK: begin
                o_flg.fin    = r_r0 != MW'(1);
                o_flg.status = ST_NOINV;
            end
            OP_CMUL: begin mul_a = DW'(r_r1); mul_b = r_t0[MW-1:0]; end
            OP_TMUL: begin mul_a = r_part;    mul_b = r_c;          end
            OP_ACC:  o_flg.cond = !w_last;
            OP_DONE: o_flg.fin = 1'b1;
            default: o_flg.fin = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait <= 1'b0;
            r_k    <= '0;
        end else if (i_load) begin
            r_wait <= 1'b0;
            r_k    <= '0;
        end else if (i_ctl.run) begin
            if (div_done) begin
                r_wait <= 1'b0;
            end else if (div_start) begin
                r_wait <= 1'b1;
            end
            if ((i_ctl.op == OP_GCHK && !o_flg.fin) || i_ctl.op == OP_ACC) begin
                r_k <= w_last ? 2'd0 : r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_m0 <= MW'(i_mod0);
            r_m1 <= MW'(i_mod1);
            r_m2 <= MW'(i_mod2);
            r_a0 <= MW'(i_res0);
            r_a1 <= MW'(i_res1);
            r_a2 <= MW'(i_res2);
            r_x  <= '0;
        end else if (i_ctl.run) begin
            case (i_ctl.op)
                OP_GINIT: begin r_r0 <= g_a; r_r1 <= g_b; end
                OP_GDIV, OP_EDIV: begin
                    if (div_done) begin
                        r_r0 <= r_r1;
                        r_r1 <= div_rem;
                        r_q  <= div_quo[MW-1:0];
                    end
                end
                OP_BIG1, OP_PART: r_part <= w_prod[DW-1:0];
                OP_BIG2: r_big <= w_prod;
                OP_PMOD: begin
                    if (div_done) begin
                        r_r1 <= div_rem;
                        r_r0 <= m_k;
                        r_t0 <= '0;
                        r_t1 <= TW'(1);
                    end
                end
                OP_ETUP: begin
                    r_t0 <= r_t1;
                    r_t1 <= r_t0 - w_qt;
                end
                OP_ICHK: if (r_t0 < 0) r_t0 <= w_tpos;
                OP_RMOD: if (div_done) r_r1 <= div_rem;
                OP_CMOD: if (div_done) r_c <= div_rem;
                OP_CMUL, OP_TMUL: r_term <= w_prod;
                OP_ACC: r_x <= w_sum >= {1'b0, r_big} ? w_sub[BW-1:0] : w_sum[BW-1:0];
                default: ;
            endcase
        end
    end

    assign o_x = r_x;

endmodule
`default_nettype wire

/* hw/rtl/crt_three_moduli_solver.sv */
// Three-moduli CRT solver top: request handshake, result register, sequencer and datapath.
// Depends on crt3_pkg, crt3_seq, crt3_dp (and crt3_div through crt3_dp).
// Timing: each division step runs on the shared divider and holds its program step
// until the divider signals done.
// Throughput: one request at a time; the next is taken as soon as the result is registered.
// Reset: synchronous active-low, clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none
module crt_three_moduli_solver
    import crt3_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic [IN_W-1:0] i_modulus_one,
    input  wire logic [IN_W-1:0] i_modulus_two,
    input  wire logic [IN_W-1:0] i_modulus_three,
    input  wire logic [IN_W-1:0] i_residue_one,
    input  wire logic [IN_W-1:0] i_residue_two,
    input  wire logic [IN_W-1:0] i_residue_three,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [SOL_W-1:0]     o_solution,
    output logic [1:0]           o_status
);

    t_ctl             w_ctl;
    t_flg             w_flg;
    logic             w_start, w_fire, w_out_free;
    logic [BW-1:0]    w_x;
    logic [63:0]      w_xw;
    logic             r_ov;
    logic [SOL_W-1:0] r_sol;
    logic [1:0]       r_sts;

    assign o_in_stall = w_ctl.run;
    assign w_start    = i_in_valid && !w_ctl.run;
    assign w_out_free = !r_ov || !i_out_stall;
    assign w_xw       = 64'(w_x);

    crt3_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_flg      (w_flg),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl),
        .o_fire     (w_fire)
    );

    crt3_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_start),
        .i_mod0  (i_modulus_one),
        .i_mod1  (i_modulus_two),
        .i_mod2  (i_modulus_three),
        .i_res0  (i_residue_one),
        .i_res1  (i_residue_two),
        .i_res2  (i_residue_three),
        .i_ctl   (w_ctl),
        .o_flg   (w_flg),
        .o_x     (w_x)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_fire) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_sts <= w_flg.status;
            r_sol <= (w_flg.status == ST_OK) ? w_xw[SOL_W-1:0] : '0;
        end
    end

    assign o_out_valid = r_ov;
    assign o_solution  = r_sol;
    assign o_status    = r_sts;

`ifndef ASSERT_OFF
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_solution == '0)
        else $error("failed request carries a solution");
    a_fire_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> w_out_free) else $error("result overwrote a pending one");
    a_fire_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid && !o_in_stall) else $error("result not presented");
`endif

endmodule
`default_nettype wire
